>>> sv/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Response frame deframer package
// Shared widths, register indexes, the result item layout and the CRC-32 step.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  MARKER    = 8'hFB;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EXPECTED_PID   = 2'd0,
        CFG_EXPECTED_CID   = 2'd1,
        CFG_CHECK_DATA_CRC = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        FT_COMMAND = 2'd0,
        FT_MEASURE = 2'd1,
        FT_OTHER   = 2'd2
    } t_frame_type;

    // Result item as it travels on the output tdata, lowest field last.
    typedef struct packed {
        logic        pad;
        logic [7:0]  result_code;
        logic        short_payload;
        logic        cid_mismatch;
        logic        pid_mismatch;
        logic        crc_error;
        logic        accepted;
        logic [7:0]  frame_pid;
        logic [1:0]  frame_type;
        logic [7:0]  data_byte;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    // One byte of the reflected CRC-32 with preset and final inversion folded
    // into the stored value, so a chain of calls matches a running CRC.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc;
        c = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return ~c;
    endfunction

    function automatic t_frame_type type_code(input logic [7:0] t);
        if (t == 8'd0) begin
            return FT_COMMAND;
        end else if (t == 8'd1) begin
            return FT_MEASURE;
        end
        return FT_OTHER;
    endfunction

endpackage

>>> sv/response_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Response frame deframer core
// Hunts for the frame marker, parses the prolog, streams payload bytes and
// reports a checked frame end with CRC, PID and CID status.
// ----------------------------------------------------------------------------
// Pipeline: the input register takes an item at the accepting edge, and the
// result register takes its result item when the output is not stalled.
// Throughput: one input item per cycle unless the output stalls; the byte-wide
// CRC-32 update and the length compare sit between input and result register.
// Reset (synchronous, active low): parser returns to marker hunt, both stages
// empty, expected PID and CID cleared, data CRC checking enabled.
module response_frame_deframer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // rx_byte
    input  logic                            s_axis_tuser,   // kind
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_byte[7:0], frame_type[9:8], frame_pid[17:10], accepted[18],
    // crc_error[19], pid_mismatch[20], cid_mismatch[21], short_payload[22],
    // result_code[30:23], zero[31]
    output logic [rfd_pkg::RESULT_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tuser    // result_kind
);
    import rfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PROLOG,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    // Configuration
    logic [7:0]  r_expected_pid;
    logic [15:0] r_expected_cid;
    logic        r_check_data_crc;

    // Input stage
    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_byte;

    // Parser state
    t_phase      r_phase,          n_phase;
    logic [31:0] r_byte_counter,   n_byte_counter;
    logic [7:0]  r_held_pid,       n_held_pid;
    logic [7:0]  r_held_type,      n_held_type;
    logic [31:0] r_payload_length, n_payload_length;
    logic [31:0] r_crc,            n_crc;
    logic [15:0] r_held_cid,       n_held_cid;
    logic [7:0]  r_held_rc,        n_held_rc;
    logic [31:0] r_received_crc,   n_received_crc;

    // Result stage
    logic        r_out_valid;
    logic        r_out_kind;
    t_result     r_out_data;

    logic        out_ready;
    logic        proc;
    logic        emit;
    logic        emit_kind;
    t_result     emit_data;
    logic [31:0] cnt_inc;
    logic        crc_bad;
    logic        pm;
    logic        cm;
    logic        sp;
    logic [7:0]  rc;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign proc          = r_in_valid && out_ready;
    assign cnt_inc       = r_byte_counter + 32'd1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    always_comb begin
        n_phase          = r_phase;
        n_byte_counter   = r_byte_counter;
        n_held_pid       = r_held_pid;
        n_held_type      = r_held_type;
        n_payload_length = r_payload_length;
        n_crc            = r_crc;
        n_held_cid       = r_held_cid;
        n_held_rc        = r_held_rc;
        n_received_crc   = r_received_crc;
        emit             = 1'b0;
        emit_kind        = 1'b0;
        emit_data        = '0;
        crc_bad          = 1'b0;
        pm               = 1'b0;
        cm               = 1'b0;
        sp               = 1'b0;
        rc               = '0;

        if (r_in_kind) begin
            // Restart drops the frame in progress.
            n_phase        = PH_HUNT;
            n_byte_counter = '0;
        end else begin
            unique case (r_phase)
                PH_PROLOG: begin
                    n_crc = crc_byte(r_crc, r_in_byte);
                    if (r_byte_counter == 32'd0) begin
                        n_held_pid = r_in_byte;
                    end else if (r_byte_counter == 32'd1) begin
                        n_held_type = r_in_byte;
                    end else begin
                        n_payload_length = {r_payload_length[23:0], r_in_byte};
                    end
                    if (r_byte_counter == 32'd5) begin
                        n_byte_counter = '0;
                        n_phase = (n_payload_length == 32'd0) ? PH_CRC : PH_PAYLOAD;
                    end else begin
                        n_byte_counter = cnt_inc;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc = crc_byte(r_crc, r_in_byte);
                    // Command answers keep CID and result code out of the stream.
                    if (r_held_type == 8'd0 && r_byte_counter < 32'd3) begin
                        if (r_byte_counter < 32'd2) begin
                            n_held_cid = {r_held_cid[7:0], r_in_byte};
                        end else begin
                            n_held_rc = r_in_byte;
                        end
                    end else begin
                        emit                 = 1'b1;
                        emit_data.data_byte  = r_in_byte;
                        emit_data.frame_type = type_code(r_held_type);
                        emit_data.frame_pid  = r_held_pid;
                    end
                    if (cnt_inc >= r_payload_length) begin
                        n_byte_counter = '0;
                        n_phase        = PH_CRC;
                    end else begin
                        n_byte_counter = cnt_inc;
                    end
                end
                PH_CRC: begin
                    n_received_crc = {r_received_crc[23:0], r_in_byte};
                    if (r_byte_counter == 32'd3) begin
                        crc_bad = (n_received_crc != r_crc);
                        if (r_held_type == 8'd0) begin
                            pm = (r_held_pid != r_expected_pid);
                            if (r_payload_length < 32'd3) begin
                                sp = 1'b1;
                            end else begin
                                cm = (r_held_cid != r_expected_cid);
                                rc = r_held_rc;
                            end
                            emit_data.accepted = !crc_bad && !pm && !sp && !cm
                                                 && (rc == 8'd0);
                        end else if (r_held_type == 8'd1) begin
                            emit_data.accepted = !crc_bad || !r_check_data_crc;
                        end
                        emit                    = 1'b1;
                        emit_kind               = 1'b1;
                        emit_data.frame_type    = type_code(r_held_type);
                        emit_data.frame_pid     = r_held_pid;
                        emit_data.crc_error     = crc_bad;
                        emit_data.pid_mismatch  = pm;
                        emit_data.cid_mismatch  = cm;
                        emit_data.short_payload = sp;
                        emit_data.result_code   = rc;
                        n_phase                 = PH_HUNT;
                        n_byte_counter          = '0;
                    end else begin
                        n_byte_counter = cnt_inc;
                    end
                end
                PH_HUNT: begin
                    if (r_in_byte == MARKER) begin
                        n_crc            = crc_byte(32'd0, r_in_byte);
                        n_phase          = PH_PROLOG;
                        n_byte_counter   = '0;
                        n_payload_length = '0;
                        n_held_cid       = '0;
                        n_held_rc        = '0;
                        n_received_crc   = '0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_pid   <= '0;
            r_expected_cid   <= '0;
            r_check_data_crc <= 1'b1;
            r_in_valid       <= 1'b0;
            r_in_kind        <= 1'b0;
            r_phase          <= PH_HUNT;
            r_byte_counter   <= '0;
            r_held_pid       <= '0;
            r_held_type      <= '0;
            r_payload_length <= '0;
            r_crc            <= '0;
            r_held_cid       <= '0;
            r_held_rc        <= '0;
            r_received_crc   <= '0;
            r_out_valid      <= 1'b0;
            r_out_kind       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_EXPECTED_PID:   r_expected_pid   <= i_cfg_wdata[7:0];
                    CFG_EXPECTED_CID:   r_expected_cid   <= i_cfg_wdata;
                    CFG_CHECK_DATA_CRC: r_check_data_crc <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
                r_in_kind  <= s_axis_tuser;
            end

            if (proc) begin
                r_phase          <= n_phase;
                r_byte_counter   <= n_byte_counter;
                r_held_pid       <= n_held_pid;
                r_held_type      <= n_held_type;
                r_payload_length <= n_payload_length;
                r_crc            <= n_crc;
                r_held_cid       <= n_held_cid;
                r_held_rc        <= n_held_rc;
                r_received_crc   <= n_received_crc;
            end

            if (out_ready) begin
                r_out_valid <= proc && emit;
                r_out_kind  <= emit_kind;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (out_ready) begin
            r_out_data <= emit_data;
        end
    end

`ifndef ASSERT_OFF
    a_end_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && emit && emit_kind) |=> (r_phase == PH_HUNT && r_byte_counter == 32'd0))
        else $error("parser did not return to marker hunt after a frame end");

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_payload_length != 32'd0))
        else $error("payload phase entered with zero length");

    a_data_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kind) |-> (!r_out_data.accepted && !r_out_data.crc_error
            && !r_out_data.pid_mismatch && !r_out_data.cid_mismatch
            && !r_out_data.short_payload && r_out_data.result_code == 8'd0))
        else $error("payload item carries frame status");

    a_other_never_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind && r_out_data.frame_type == FT_OTHER)
            |-> !r_out_data.accepted)
        else $error("frame of unknown type was accepted");
`endif

endmodule

>>> verif/tb_response_frame_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Response frame deframer core testbench
// Sends framed byte streams, noise, truncated frames and restarts into the
// deframer. A local parser predicts every payload and frame-end item, and the
// checker compares each output item field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_response_frame_deframer_core;
    import rfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 300;

    typedef enum logic [1:0] {
        P_HUNT    = 2'd0,
        P_PROLOG  = 2'd1,
        P_PAYLOAD = 2'd2,
        P_CRC     = 2'd3
    } t_parse;

    typedef struct packed {
        logic    kind;
        t_result res;
    } t_expected;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RESULT_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    response_frame_deframer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predicted parser state and register copies.
    t_parse      parse_ph   = P_HUNT;
    logic [31:0] byte_cnt   = '0;
    logic [7:0]  frm_pid    = '0;
    logic [7:0]  frm_type   = '0;
    logic [31:0] pay_len    = '0;
    logic [31:0] crc_run    = '0;
    logic [15:0] cid_held   = '0;
    logic [7:0]  rcode_held = '0;
    logic [31:0] crc_rx     = '0;
    logic [7:0]  exp_pid    = '0;
    logic [15:0] exp_cid    = '0;
    logic        chk_crc    = 1'b1;

    t_expected   pending_results[$];
    logic [7:0]  frame_buf[$];

    int          errors          = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          frames_sent     = 0;
    int          frames_cut      = 0;
    int          noise_bursts    = 0;
    int          src_idle_pct    = 0;
    int          sink_stall_pct  = 0;
    logic        sink_hold       = 1'b0;
    int          quiet_cycles    = 0;
    t_expected   want;
    t_result     got;

    // Reflected CRC-32, data bits fed in one at a time, inversions folded in.
    function automatic logic [31:0] crc32_next(input logic [31:0] sum, input logic [7:0] d);
        logic [31:0] r;
        r = ~sum;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ d[k]) begin
                r = (r >> 1) ^ 32'hEDB88320;
            end else begin
                r = r >> 1;
            end
        end
        return ~r;
    endfunction

    function automatic logic [1:0] frame_class();
        if (frm_type == 8'd0) begin
            return FT_COMMAND;
        end else if (frm_type == 8'd1) begin
            return FT_MEASURE;
        end
        return FT_OTHER;
    endfunction

    // Advances the predicted parser by one accepted input item.
    function automatic void deframe_byte(input logic kind, input logic [7:0] b);
        t_expected e;
        logic      held;
        e = '0;
        held = 1'b0;
        if (kind) begin
            parse_ph = P_HUNT;
            byte_cnt = '0;
            return;
        end
        case (parse_ph)
            P_PROLOG: begin
                crc_run = crc32_next(crc_run, b);
                if (byte_cnt == 0) begin
                    frm_pid = b;
                end else if (byte_cnt == 1) begin
                    frm_type = b;
                end else begin
                    pay_len = {pay_len[23:0], b};
                end
                byte_cnt++;
                if (byte_cnt >= 6) begin
                    byte_cnt = '0;
                    parse_ph = (pay_len == 0) ? P_CRC : P_PAYLOAD;
                end
            end
            P_PAYLOAD: begin
                crc_run = crc32_next(crc_run, b);
                // Command answers keep CID and result code back from the stream.
                if (frm_type == 8'd0 && byte_cnt < 3) begin
                    held = 1'b1;
                    if (byte_cnt < 2) begin
                        cid_held = {cid_held[7:0], b};
                    end else begin
                        rcode_held = b;
                    end
                end
                byte_cnt++;
                if (byte_cnt >= pay_len) begin
                    byte_cnt = '0;
                    parse_ph = P_CRC;
                end
                if (!held) begin
                    e.res.data_byte  = b;
                    e.res.frame_type = frame_class();
                    e.res.frame_pid  = frm_pid;
                    pending_results = {pending_results, e};
                end
            end
            P_CRC: begin
                crc_rx = {crc_rx[23:0], b};
                byte_cnt++;
                if (byte_cnt >= 4) begin
                    e.kind           = 1'b1;
                    e.res.frame_type = frame_class();
                    e.res.frame_pid  = frm_pid;
                    e.res.crc_error  = (crc_rx != crc_run);
                    if (frm_type == 8'd0) begin
                        e.res.pid_mismatch = (frm_pid != exp_pid);
                        if (pay_len < 3) begin
                            e.res.short_payload = 1'b1;
                        end else begin
                            e.res.cid_mismatch = (cid_held != exp_cid);
                            e.res.result_code  = rcode_held;
                        end
                        e.res.accepted = !(e.res.crc_error | e.res.pid_mismatch
                                           | e.res.short_payload | e.res.cid_mismatch)
                                         && e.res.result_code == 8'd0;
                    end else if (frm_type == 8'd1) begin
                        e.res.accepted = !e.res.crc_error || !chk_crc;
                    end
                    pending_results = {pending_results, e};
                    parse_ph = P_HUNT;
                    byte_cnt = '0;
                end
            end
            default: begin
                if (b == MARKER) begin
                    crc_run    = crc32_next(32'd0, b);
                    parse_ph   = P_PROLOG;
                    byte_cnt   = '0;
                    pay_len    = '0;
                    cid_held   = '0;
                    rcode_held = '0;
                    crc_rx     = '0;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual kind %0b data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("data_byte", 32'(want.res.data_byte), 32'(got.data_byte));
                check_field("frame_type", 32'(want.res.frame_type), 32'(got.frame_type));
                check_field("frame_pid", 32'(want.res.frame_pid), 32'(got.frame_pid));
                check_field("accepted", 32'(want.res.accepted), 32'(got.accepted));
                check_field("crc_error", 32'(want.res.crc_error), 32'(got.crc_error));
                check_field("pid_mismatch", 32'(want.res.pid_mismatch),
                            32'(got.pid_mismatch));
                check_field("cid_mismatch", 32'(want.res.cid_mismatch),
                            32'(got.cid_mismatch));
                check_field("short_payload", 32'(want.res.short_payload),
                            32'(got.short_payload));
                check_field("result_code", 32'(want.res.result_code), 32'(got.result_code));
                check_field("pad", 32'd0, 32'(got.pad));
            end
        end
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d items still expected",
                     $time, quiet_cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        deframe_byte(kind, b);
        items_sent++;
    endtask

    // Stops sending and waits until the block has delivered everything.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] pid, input logic [15:0] cid, input logic chk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_EXPECTED_PID;
        i_cfg_wdata <= {8'h00, pid};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_EXPECTED_CID;
        i_cfg_wdata <= cid;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CHECK_DATA_CRC;
        i_cfg_wdata <= {15'd0, chk};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        exp_pid = pid;
        exp_cid = cid;
        chk_crc = chk;
    endtask

    task automatic build_frame(input logic [7:0] pid, input logic [7:0] ftype,
                               input logic [31:0] len, input logic [15:0] cid,
                               input logic [7:0] rcode, input bit bad_crc);
        logic [31:0] sum;
        frame_buf = {MARKER, pid, ftype, len[31:24], len[23:16], len[15:8], len[7:0]};
        for (int k = 0; k < len; k++) begin
            if (ftype == 8'd0 && k == 0) begin
                frame_buf = {frame_buf, cid[15:8]};
            end else if (ftype == 8'd0 && k == 1) begin
                frame_buf = {frame_buf, cid[7:0]};
            end else if (ftype == 8'd0 && k == 2) begin
                frame_buf = {frame_buf, rcode};
            end else begin
                frame_buf = {frame_buf, 8'($urandom)};
            end
        end
        sum = '0;
        foreach (frame_buf[k]) begin
            sum = crc32_next(sum, frame_buf[k]);
        end
        if (bad_crc) begin
            sum = sum ^ (32'd1 << $urandom_range(31));
        end
        frame_buf = {frame_buf, sum[31:24]};
        frame_buf = {frame_buf, sum[23:16]};
        frame_buf = {frame_buf, sum[15:8]};
        frame_buf = {frame_buf, sum[7:0]};
    endtask

    // Sends the first n bytes of the built frame.
    task automatic send_frame_bytes(input int n);
        for (int k = 0; k < n; k++) begin
            send_item(1'b0, frame_buf[k]);
        end
        frames_sent++;
    endtask

    task automatic send_frame(input logic [7:0] pid, input logic [7:0] ftype,
                              input logic [31:0] len, input logic [15:0] cid,
                              input logic [7:0] rcode, input bit bad_crc);
        build_frame(pid, ftype, len, cid, rcode, bad_crc);
        send_frame_bytes(frame_buf.size());
    endtask

    task automatic test_directed_frames();
        configure(8'h5A, 16'hBEEF, 1'b1);
        // Bytes other than the marker are ignored while hunting, and so is a
        // restart whose byte happens to be the marker.
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, MARKER);
        send_frame(8'h5A, 8'd0, 32'd5, 16'hBEEF, 8'h00, 1'b0);
        send_frame(8'h5A, 8'd0, 32'd3, 16'hBEEF, 8'hFF, 1'b0);
        send_frame(8'h5A, 8'd0, 32'd4, 16'h0000, 8'h00, 1'b0);
        send_frame(8'hA5, 8'd0, 32'd3, 16'hBEEF, 8'h00, 1'b0);
        send_frame(8'h5A, 8'd0, 32'd5, 16'hBEEF, 8'h00, 1'b1);
        send_frame(8'h5A, 8'd0, 32'd2, 16'h1234, 8'h77, 1'b0);
        send_frame(8'h00, 8'd0, 32'd0, 16'h0000, 8'h00, 1'b0);
        send_frame(8'hFF, 8'd1, 32'd4, 16'h0000, 8'h00, 1'b0);
        send_frame(8'h5A, 8'd1, 32'd3, 16'h0000, 8'h00, 1'b1);
        send_frame(8'h5A, 8'd2, 32'd1, 16'h0000, 8'h00, 1'b0);
        send_frame(8'h5A, 8'hFF, 32'd0, 16'h0000, 8'h00, 1'b0);
        // A restart in the middle of a frame drops it.
        build_frame(8'h5A, 8'd0, 32'd6, 16'hBEEF, 8'h00, 1'b0);
        send_frame_bytes(9);
        frames_cut++;
        send_item(1'b1, 8'h00);
        send_frame(8'h5A, 8'd0, 32'd6, 16'hBEEF, 8'h00, 1'b0);
        settle_block();
        // With data checking off a measurement frame with a bad CRC is taken.
        configure(8'h5A, 16'hBEEF, 1'b0);
        send_frame(8'h5A, 8'd1, 32'd2, 16'h0000, 8'h00, 1'b1);
        settle_block();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int          budget;
        int          pick;
        logic [7:0]  ftype;
        logic [31:0] len;
        budget = PHASE_ITEMS;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (budget > 0) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                ftype = 8'd0;
            end else if (pick < 85) begin
                ftype = 8'd1;
            end else begin
                ftype = 8'($urandom_range(2, 255));
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            build_frame(($urandom_range(9) < 7) ? exp_pid : 8'($urandom), ftype, len,
                        ($urandom_range(9) < 7) ? exp_cid : 16'($urandom),
                        ($urandom_range(3) != 0) ? 8'h00 : 8'($urandom),
                        $urandom_range(99) < 15);
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_frame_bytes(frame_buf.size());
                budget -= frame_buf.size();
            end else if (pick < 90) begin
                // Noise may start a frame with a huge length; the restart ends it.
                repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom));
                send_item(1'b1, 8'($urandom));
                noise_bursts++;
            end else begin
                pick = $urandom_range(1, frame_buf.size() - 1);
                send_frame_bytes(pick);
                send_item(1'b1, 8'($urandom));
                frames_cut++;
                budget -= pick;
            end
        end
        settle_block();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            begin
                repeat (4) send_frame(exp_pid, 8'd1, 32'd10, 16'h0000, 8'h00, 1'b0);
            end
        join
        settle_block();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_output_backpressure();
        configure(8'h00, 16'h0000, 1'b1);
        test_random_traffic(0, 0);
        configure(8'hFF, 16'hFFFF, 1'b0);
        test_random_traffic(53, 0);
        configure(8'($urandom), 16'($urandom), 1'b1);
        test_random_traffic(0, 53);
        configure(8'($urandom), 16'($urandom), 1'($urandom));
        test_random_traffic(30, 30);
        settle_block();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items in %0d frames (%0d cut short) and %0d noise bursts,",
                 items_sent, frames_sent, frames_cut, noise_bursts);
        $display("checked %0d output items under four idle mixes and a long output stall.",
                 results_checked);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rfd_pkg.sv
sv/response_frame_deframer_core.sv
verif/tb_response_frame_deframer_core.sv
